[hdl/qed_pkg.sv]
// Shared types and constants for the quadrature encoder decoder.
`timescale 1ns / 1ps

package qed_pkg;

    // Configuration register indexes (byte address is four times the index)
    localparam int unsigned CfgAddrWidth = 4;
    localparam logic [1:0] REG_DEBOUNCE  = 2'd0;
    localparam logic [1:0] REG_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_FAST_STEP = 2'd2;
    localparam logic [1:0] REG_ACCEL     = 2'd3;

    localparam logic [7:0]  DEBOUNCE_RESET  = 8'd200;
    localparam logic [31:0] THRESHOLD_RESET = 32'd100;
    localparam logic [6:0]  FAST_STEP_RESET = 7'd4;
    localparam logic        ACCEL_RESET     = 1'b1;

    // Event codes as reported on event_code
    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_CW       = 3'd1;
    localparam logic [2:0] EV_CW_FAST  = 3'd2;
    localparam logic [2:0] EV_CCW      = 3'd3;
    localparam logic [2:0] EV_CCW_FAST = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_AFIRST = 3'b010,
        ST_BFIRST = 3'b100
    } decode_state_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_CW   = 2'd1,
        DIR_CCW  = 2'd2
    } dir_t;

    typedef struct packed {
        logic [7:0]  debounce_ticks;
        logic [31:0] fast_threshold_ms;
        logic [6:0]  fast_step;
        logic        accel_on;
    } cfg_t;

    typedef struct packed {
        logic        phase_a;
        logic        phase_b;
        logic [31:0] now_ms;
        logic        take_event;
        logic        take_delta;
        logic        zero_position;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         event_code;
        logic signed [31:0] position_out;
        logic signed [31:0] delta_out;
    } out_item_t;

endpackage

[hdl/qed_stream_if.sv]
// Valid/ready channel interfaces for sampling ticks and results.
`timescale 1ns / 1ps

interface qed_in_if;
    import qed_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface qed_out_if;
    import qed_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[hdl/qed_regs.sv]
// APB-style configuration register file.
`timescale 1ns / 1ps

module qed_regs
    import qed_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [CfgAddrWidth-1:0] paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    output cfg_t                    cfg
);

    cfg_t       cfg_reg;
    logic [1:0] reg_index;
    logic       wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[CfgAddrWidth-1:2];
    assign wr_en     = psel && penable && pwrite;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks    <= DEBOUNCE_RESET;
            cfg_reg.fast_threshold_ms <= THRESHOLD_RESET;
            cfg_reg.fast_step         <= FAST_STEP_RESET;
            cfg_reg.accel_on          <= ACCEL_RESET;
        end
        else if (wr_en)
        begin
            case (reg_index)
                REG_DEBOUNCE:  cfg_reg.debounce_ticks    <= pwdata[7:0];
                REG_THRESHOLD: cfg_reg.fast_threshold_ms <= pwdata;
                REG_FAST_STEP: cfg_reg.fast_step         <= pwdata[6:0];
                REG_ACCEL:     cfg_reg.accel_on          <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_DEBOUNCE:  prdata = {24'd0, cfg_reg.debounce_ticks};
            REG_THRESHOLD: prdata = cfg_reg.fast_threshold_ms;
            REG_FAST_STEP: prdata = {25'd0, cfg_reg.fast_step};
            REG_ACCEL:     prdata = {31'd0, cfg_reg.accel_on};
            default:       prdata = 32'd0;
        endcase
    end

endmodule

[hdl/qed_core.sv]
// Input register, decoder state update and result register.
`timescale 1ns / 1ps

module qed_core
    import qed_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    qed_in_if.sink        in_ch,
    qed_out_if.source     out_ch
);

    // Input stage
    logic          in_valid_reg;
    in_item_t      in_item_reg;
    // Result stage
    logic          out_valid_reg;
    out_item_t     out_item_reg;

    // Decoder state
    decode_state_t dstate_reg, dstate_next;
    logic          prev_a_reg, prev_a_next;
    logic          prev_b_reg, prev_b_next;
    logic [7:0]    settle_reg, settle_next;
    dir_t          pending_reg, pending_next;
    logic [31:0]   pos_reg, pos_next, pos_upd;
    logic [31:0]   delta_reg, delta_next, delta_upd;
    logic [31:0]   last_time_reg, last_time_next;
    logic [2:0]    latched_reg, latched_next, latched_upd;
    logic [2:0]    event_out;

    logic          advance;
    logic          fire;
    logic          fast;
    logic [31:0]   step;
    logic [31:0]   interval;
    logic [7:0]    arm_count;
    logic          a_in, b_in;

    assign advance      = !out_valid_reg || out_ch.ready;
    assign fire         = advance && in_valid_reg;
    assign in_ch.ready  = !in_valid_reg || advance;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.payload = out_item_reg;

    assign a_in      = in_item_reg.phase_a;
    assign b_in      = in_item_reg.phase_b;
    assign interval  = in_item_reg.now_ms - last_time_reg;
    assign fast      = interval < cfg.fast_threshold_ms;
    assign step      = (fast && cfg.accel_on) ? {25'd0, cfg.fast_step} : 32'd1;
    // A zero settle time is treated as one tick.
    assign arm_count = (cfg.debounce_ticks == 8'd0) ? 8'd1 : cfg.debounce_ticks;

    always_comb
    begin
        dstate_next    = dstate_reg;
        prev_a_next    = prev_a_reg;
        prev_b_next    = prev_b_reg;
        settle_next    = settle_reg;
        pending_next   = pending_reg;
        pos_upd        = pos_reg;
        delta_upd      = delta_reg;
        last_time_next = last_time_reg;
        latched_upd    = latched_reg;

        if (settle_reg != 8'd0)
        begin
            settle_next = settle_reg - 8'd1;
            if (settle_next == 8'd0 && pending_reg != DIR_NONE)
            begin
                last_time_next = in_item_reg.now_ms;
                pending_next   = DIR_NONE;
                if (pending_reg == DIR_CW)
                begin
                    pos_upd     = pos_reg + step;
                    delta_upd   = delta_reg + step;
                    latched_upd = fast ? EV_CW_FAST : EV_CW;
                end
                else
                begin
                    pos_upd     = pos_reg - step;
                    delta_upd   = delta_reg - step;
                    latched_upd = fast ? EV_CCW_FAST : EV_CCW;
                end
            end
        end
        else
        begin
            case (dstate_reg)
                ST_AFIRST:
                begin
                    if (a_in != prev_a_reg)
                    begin
                        // A moved again before B: start over from the current levels.
                        prev_a_next = a_in;
                        prev_b_next = b_in;
                        dstate_next = ST_IDLE;
                    end
                    else if (b_in != prev_b_reg)
                    begin
                        if (a_in == b_in)
                        begin
                            pending_next = DIR_CW;
                            settle_next  = arm_count;
                            dstate_next  = ST_IDLE;
                        end
                        prev_b_next = b_in;
                    end
                end
                ST_BFIRST:
                begin
                    if (b_in != prev_b_reg)
                    begin
                        prev_a_next = a_in;
                        prev_b_next = b_in;
                        dstate_next = ST_IDLE;
                    end
                    else if (a_in != prev_a_reg)
                    begin
                        if (a_in == b_in)
                        begin
                            pending_next = DIR_CCW;
                            settle_next  = arm_count;
                            dstate_next  = ST_IDLE;
                        end
                        prev_a_next = a_in;
                    end
                end
                default:
                begin
                    if (a_in != prev_a_reg)
                    begin
                        prev_a_next = a_in;
                        dstate_next = ST_AFIRST;
                    end
                    else if (b_in != prev_b_reg)
                    begin
                        prev_b_next = b_in;
                        dstate_next = ST_BFIRST;
                    end
                end
            endcase
        end

        // Queries see the state after this tick's update.
        event_out    = in_item_reg.take_event ? latched_upd : EV_NONE;
        latched_next = in_item_reg.take_event ? EV_NONE : latched_upd;
        pos_next     = in_item_reg.zero_position ? 32'd0 : pos_upd;
        delta_next   = in_item_reg.take_delta ? 32'd0 : delta_upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            dstate_reg    <= ST_IDLE;
            prev_a_reg    <= 1'b1;
            prev_b_reg    <= 1'b1;
            settle_reg    <= 8'd0;
            pending_reg   <= DIR_NONE;
            pos_reg       <= 32'd0;
            delta_reg     <= 32'd0;
            last_time_reg <= 32'd0;
            latched_reg   <= EV_NONE;
        end
        else
        begin
            if (in_ch.ready)
            begin
                in_valid_reg <= in_ch.valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire)
            begin
                dstate_reg    <= dstate_next;
                prev_a_reg    <= prev_a_next;
                prev_b_reg    <= prev_b_next;
                settle_reg    <= settle_next;
                pending_reg   <= pending_next;
                pos_reg       <= pos_next;
                delta_reg     <= delta_next;
                last_time_reg <= last_time_next;
                latched_reg   <= latched_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            in_item_reg <= in_ch.payload;
        end
        if (fire)
        begin
            out_item_reg.event_code   <= event_out;
            out_item_reg.position_out <= pos_upd;
            out_item_reg.delta_out    <= delta_upd;
        end
    end

endmodule

[hdl/quadrature_encoder_decoder_unit.sv]
// Top level of the quadrature encoder decoder.
//
//  Channel  Direction  Carries
//  in_ch    sink       one sampling tick: phases, now_ms, query flags
//  out_ch   source     one result per tick: event_code, position_out, delta_out
//  APB      slave      four configuration registers at byte addresses 0, 4, 8, 12
//
// Each tick is held in the input register and then in the result register; one tick is taken
// per cycle while the output is not stalled, and the decoder state registers are updated as
// each tick moves from the input register into the result register.
// A stalled output holds its result while one further tick waits in the input register.
// Reset is asynchronous and active low; it restores register defaults and decoder state.
`timescale 1ns / 1ps

module quadrature_encoder_decoder_unit
    import qed_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    qed_in_if.sink                  in_ch,
    qed_out_if.source               out_ch,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [CfgAddrWidth-1:0] paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    cfg_t cfg;

    qed_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    qed_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

endmodule

[hdl/qed_checker.sv]
// Port-level checks for the quadrature encoder decoder, bound to the top level.
`timescale 1ns / 1ps

module qed_checker
    import qed_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input out_item_t out_payload,
    input logic pready
);

    // Only the five defined event codes may appear.
    a_event_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_payload.event_code <= EV_CCW_FAST))
        else $error("event_code out of range");

    // With no result waiting, the block must be able to take a tick.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output register empty");

    // A stalled result keeps its value until the transaction completes.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_payload))
        else $error("result changed while stalled");

    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind quadrature_encoder_decoder_unit qed_checker u_qed_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_payload (out_ch.payload),
    .pready      (pready)
);

[bench/tb_top.sv]
// Self-checking testbench for the quadrature encoder decoder unit.
`timescale 1ns / 1ps

module tb_top;
    import qed_pkg::*;

    localparam int unsigned QuietLimit = 2000;

    // Tracks the decoder state alongside the block and checks every result against it.
    class encoder_scoreboard;
        cfg_t               cfg;
        decode_state_t      phase_state;
        dir_t               pending_dir;
        logic               last_a;
        logic               last_b;
        logic [7:0]         settle;
        logic [31:0]        position;
        logic [31:0]        delta;
        logic [31:0]        last_step_ms;
        logic [2:0]         latched;
        out_item_t          expected_q[$];
        int unsigned        mismatches;
        int unsigned        ticks;
        int unsigned        checked;
        int unsigned        steps;
        int unsigned        fast_steps;

        function new();
            cfg          = '{DEBOUNCE_RESET, THRESHOLD_RESET, FAST_STEP_RESET, ACCEL_RESET};
            phase_state  = ST_IDLE;
            pending_dir  = DIR_NONE;
            last_a       = 1'b1;
            last_b       = 1'b1;
            settle       = '0;
            position     = '0;
            delta        = '0;
            last_step_ms = '0;
            latched      = EV_NONE;
            mismatches   = 0;
            ticks        = 0;
            checked      = 0;
            steps        = 0;
            fast_steps   = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_DEBOUNCE:  cfg.debounce_ticks    = value[7:0];
                REG_THRESHOLD: cfg.fast_threshold_ms = value;
                REG_FAST_STEP: cfg.fast_step         = value[6:0];
                REG_ACCEL:     cfg.accel_on          = value[0];
                default: ;
            endcase
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        // A zero debounce setting still costs one tick before the step lands.
        function void arm_step(dir_t dir);
            pending_dir = dir;
            settle      = (cfg.debounce_ticks == 8'd0) ? 8'd1 : cfg.debounce_ticks;
            phase_state = ST_IDLE;
        endfunction

        function void apply_step(logic [31:0] now);
            logic [31:0] interval;
            logic [31:0] amount;
            bit          fast;
            interval     = now - last_step_ms;
            fast         = interval < cfg.fast_threshold_ms;
            amount       = (fast && cfg.accel_on) ? 32'(cfg.fast_step) : 32'd1;
            last_step_ms = now;
            if (pending_dir == DIR_CW)
            begin
                position = position + amount;
                delta    = delta + amount;
                latched  = fast ? EV_CW_FAST : EV_CW;
            end
            else
            begin
                position = position - amount;
                delta    = delta - amount;
                latched  = fast ? EV_CCW_FAST : EV_CCW;
            end
            pending_dir = DIR_NONE;
            steps++;
            if (fast)
                fast_steps++;
        endfunction

        function void sample_phases(logic a, logic b);
            case (phase_state)
                ST_AFIRST:
                begin
                    if (a != last_a)
                    begin
                        last_a      = a;
                        last_b      = b;
                        phase_state = ST_IDLE;
                    end
                    else if (b != last_b)
                    begin
                        if (a == b)
                            arm_step(DIR_CW);
                        last_b = b;
                    end
                end
                ST_BFIRST:
                begin
                    if (b != last_b)
                    begin
                        last_a      = a;
                        last_b      = b;
                        phase_state = ST_IDLE;
                    end
                    else if (a != last_a)
                    begin
                        if (a == b)
                            arm_step(DIR_CCW);
                        last_a = a;
                    end
                end
                default:
                begin
                    if (a != last_a)
                    begin
                        last_a      = a;
                        phase_state = ST_AFIRST;
                    end
                    else if (b != last_b)
                    begin
                        last_b      = b;
                        phase_state = ST_BFIRST;
                    end
                end
            endcase
        endfunction

        function void note_tick(in_item_t t);
            out_item_t r;
            ticks++;
            if (settle != 8'd0)
            begin
                settle = settle - 8'd1;
                if (settle == 8'd0 && pending_dir != DIR_NONE)
                    apply_step(t.now_ms);
            end
            else
                sample_phases(t.phase_a, t.phase_b);
            r.event_code = EV_NONE;
            if (t.take_event)
            begin
                r.event_code = latched;
                latched      = EV_NONE;
            end
            r.position_out = position;
            r.delta_out    = delta;
            expected_q.push_back(r);
            if (t.take_delta)
                delta = '0;
            if (t.zero_position)
                position = '0;
        endfunction

        function void check_result(out_item_t r);
            out_item_t e;
            if (expected_q.size() == 0)
            begin
                $error("result transaction arrived with no tick outstanding");
                mismatches++;
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (r.event_code !== e.event_code)
            begin
                $error("event_code: expected %0d, actual %0d", e.event_code, r.event_code);
                mismatches++;
            end
            if (r.position_out !== e.position_out)
            begin
                $error("position_out: expected %0d, actual %0d", e.position_out, r.position_out);
                mismatches++;
            end
            if (r.delta_out !== e.delta_out)
            begin
                $error("delta_out: expected %0d, actual %0d", e.delta_out, r.delta_out);
                mismatches++;
            end
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [CfgAddrWidth-1:0] paddr;
    logic [31:0]             pwdata;
    logic [31:0]             prdata;
    logic                    pready;

    qed_in_if  in_ch ();
    qed_out_if out_ch ();

    encoder_scoreboard sb;
    int unsigned       tx_idle;
    int unsigned       rx_idle;
    int unsigned       quiet_cycles;
    int unsigned       settings_run;
    logic              lvl_a;
    logic              lvl_b;
    logic [31:0]       clock_ms;

    quadrature_encoder_decoder_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle);
    end

    // Observes both channels and ends the run if traffic stops altogether.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                sb.note_tick(in_ch.payload);
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.payload);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QuietLimit)
            begin
                $display("quadrature_encoder_decoder_unit verification failed");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    task automatic send_tick(input logic a, input logic b, input logic [31:0] now,
                             input logic ev, input logic dl, input logic zp);
        in_item_t t;
        t.phase_a       = a;
        t.phase_b       = b;
        t.now_ms        = now;
        t.take_event    = ev;
        t.take_delta    = dl;
        t.zero_position = zp;
        lvl_a    = a;
        lvl_b    = b;
        clock_ms = now;
        while ($urandom_range(99) < tx_idle)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= t;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    // Registers may only change once every outstanding result has been returned.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Mostly clean rotation in bursts, usually held long enough for the debounce to expire,
    // with occasional glitches on one or both phases and direction reversals.
    task automatic run_block(input int n, input int deb);
        int unsigned hold;
        bit          half;
        bit          ccw;
        logic        a;
        logic        b;
        logic [31:0] now;
        hold = 0;
        half = 1'b0;
        ccw  = $urandom_range(1);
        a    = lvl_a;
        b    = lvl_b;
        now  = clock_ms;
        for (int i = 0; i < n; i++)
        begin
            if (hold != 0)
                hold--;
            else if ($urandom_range(99) < 12)
            begin
                case ($urandom_range(2))
                    0: a = ~a;
                    1: b = ~b;
                    default:
                    begin
                        a = ~a;
                        b = ~b;
                    end
                endcase
                hold = $urandom_range(2);
            end
            else
            begin
                if (!half && $urandom_range(99) < 20)
                    ccw = ~ccw;
                if (half == ccw)
                    a = ~a;
                else
                    b = ~b;
                if (half)
                    hold = ($urandom_range(3) == 0) ? $urandom_range(deb)
                                                    : deb + $urandom_range(2);
                else
                    hold = $urandom_range(1);
                half = ~half;
            end
            if ($urandom_range(99) < 3)
                now = $urandom();
            else
                now = now + $urandom_range(20);
            send_tick(a, b, now, $urandom_range(99) < 40, $urandom_range(99) < 20,
                      $urandom_range(99) < 8);
        end
    endtask

    task automatic run_phase(input logic [31:0] deb, input logic [31:0] thr,
                             input logic [31:0] fstep, input logic [31:0] accel,
                             input int n, input int unsigned tx, input int unsigned rx);
        drain();
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_FAST_STEP, fstep);
        write_reg(REG_ACCEL, accel);
        tx_idle = tx;
        rx_idle = rx;
        settings_run++;
        run_block(n, deb);
    endtask

    initial
    begin
        sb            = new();
        tx_idle       = 21;
        rx_idle       = 63;
        quiet_cycles  = 0;
        settings_run  = 1;
        lvl_a         = 1'b1;
        lvl_b         = 1'b1;
        clock_ms      = '0;
        rst_n         <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.payload <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening with a one-tick debounce: clockwise and anticlockwise steps,
        // fast and slow intervals, a time wrap, a phase restart and every query flag.
        write_reg(REG_DEBOUNCE, 32'd1);
        send_tick(1'b1, 1'b1, 32'd0,          1'b1, 1'b0, 1'b0);
        send_tick(1'b0, 1'b1, 32'd10,         1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 32'd20,         1'b0, 1'b1, 1'b0);
        send_tick(1'b0, 1'b0, 32'd30,         1'b1, 1'b0, 1'b0);
        send_tick(1'b0, 1'b1, 32'd500,        1'b0, 1'b0, 1'b1);
        send_tick(1'b1, 1'b1, 32'd510,        1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b1, 32'd1000,       1'b1, 1'b1, 1'b0);
        send_tick(1'b0, 1'b1, 32'hFFFF_FFFF,  1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b1, 32'hFFFF_FFFF,  1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 32'd0,          1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 32'd5,          1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 32'd8,          1'b1, 1'b0, 1'b1);
        send_tick(1'b1, 1'b0, 32'd9,          1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b1, 32'd20,         1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b1, 32'd40,         1'b1, 1'b1, 1'b1);
        send_tick(1'b0, 1'b0, 32'h8000_0000,  1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 32'h7FFF_FFFF,  1'b1, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 32'h7FFF_FFFF,  1'b1, 1'b1, 1'b1);
        send_tick(1'b1, 1'b1, 32'h7FFF_FFFF,  1'b1, 1'b0, 1'b0);

        run_phase(32'd255, 32'd60,          32'd9,   32'd1, 100, 21, 63);
        run_phase(32'd0,   32'd0,           32'd127, 32'd1, 40,  21, 63);
        run_phase(32'd3,   32'hFFFF_FFFF,   32'd0,   32'd1, 40,  21, 63);
        run_phase(32'd2,   32'd40,          32'd127, 32'd0, 40,  63, 21);
        run_phase(32'd1,   32'd30,          32'd1,   32'd1, 40,  63, 21);
        run_phase(32'd4,   32'd25,          32'd64,  32'd1, 40,  63, 21);
        run_phase(32'd1,   32'd100,         32'd4,   32'd1, 40,  0,  0);
        run_phase(32'd0,   32'h8000_0000,   32'd127, 32'd0, 40,  0,  0);
        drain();
        repeat (8) @(posedge clk);

        $display("Ran %0d ticks over %0d register settings; %0d results checked.",
                 sb.ticks, settings_run, sb.checked);
        $display("Steps applied: %0d, of which %0d were marked fast.",
                 sb.steps, sb.fast_steps);
        if (sb.mismatches == 0)
            $display("quadrature_encoder_decoder_unit verification clean");
        else
            $display("quadrature_encoder_decoder_unit verification failed");
        $finish;
    end

endmodule

[files.f]
hdl/qed_pkg.sv
hdl/qed_stream_if.sv
hdl/qed_regs.sv
hdl/qed_core.sv
hdl/quadrature_encoder_decoder_unit.sv
hdl/qed_checker.sv
bench/tb_top.sv
